// ----- rtl/core/bst_pkg.sv -----
// Package for the byte stream tokenizer: result kinds, register indexes,
// character constants and the structs passed between the core and the emitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

  localparam int KIND_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int LIMIT_W    = 11;
  localparam int OUT_POS_W  = 32;
  localparam int LINE_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CNT_W      = 2;
  localparam int MAX_RESULTS = 3;

  localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEWLINE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_EOI  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_REPORT_NL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINUS_WORD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  localparam logic [BYTE_W-1:0] CH_TAB        = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF         = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR         = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [BYTE_W-1:0] CH_MINUS      = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_DIGIT_LO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_DIGIT_HI   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UPPER_LO   = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_HI   = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LOWER_LO   = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_HI   = 8'h7A;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [BYTE_W-1:0]    data;
    logic [OUT_POS_W-1:0] offset;
    logic [OUT_POS_W-1:0] line_offset;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [LINE_W-1:0] line;
    result_t [MAX_RESULTS-1:0] slot;
  } group_t;

  typedef struct packed {
    logic               report_nl;
    logic               minus_word;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/bst_in_if.sv -----
// Input byte channel of the tokenizer: valid/ready plus action and data byte.
// Depends on bst_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bst_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [bst_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bst_out_if.sv -----
// Result channel of the tokenizer: valid/ready plus one token result.
// Depends on bst_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bst_out_if;
  logic                          valid;
  logic                          ready;
  logic [bst_pkg::KIND_W-1:0]    out_kind;
  logic [bst_pkg::BYTE_W-1:0]    out_byte;
  logic [bst_pkg::LINE_W-1:0]    token_line;
  logic [bst_pkg::OUT_POS_W-1:0] token_offset;
  logic [bst_pkg::OUT_POS_W-1:0] token_line_offset;
  logic                          last;

  modport source (output valid, output out_kind, output out_byte, output token_line,
                  output token_offset, output token_line_offset, output last,
                  input ready);
  modport sink (input valid, input out_kind, input out_byte, input token_line,
                input token_offset, input token_line_offset, input last,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bst_cfg_if.sv -----
// Configuration write channel of the tokenizer: valid/ready, index and data.
// Depends on bst_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bst_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bst_pkg::CFG_IDX_W-1:0]  index;
  logic [bst_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bst_core.sv -----
// Tokenizer state and per-byte step: classifies the byte, updates counters
// and builds the group of up to three results. Depends on bst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bst_core #(
  parameter int POSITION_BITS    = 32,
  parameter int LENGTH_LIMIT_MAX = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic                          action,
  input  wire logic [bst_pkg::BYTE_W-1:0]    data_byte,
  input  wire bst_pkg::cfg_t                 cfg,
  output bst_pkg::group_t                    grp
);
  import bst_pkg::*;

  localparam int LIMIT_ALL = (1 << LIMIT_W) - 1;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP =
    LIMIT_W'((LENGTH_LIMIT_MAX > LIMIT_ALL) ? LIMIT_ALL : LENGTH_LIMIT_MAX);

  logic                     in_word, in_word_next;
  logic [LIMIT_W-1:0]       word_length, word_length_next;
  logic                     newline_seen, newline_seen_next;
  logic                     discarding, discarding_next;
  logic [LINE_W-1:0]        line_count, line_count_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] line_start, line_start_next;
  logic [POSITION_BITS-1:0] start_position, start_position_next;
  logic [POSITION_BITS-1:0] start_line_start, start_line_start_next;

  logic [LIMIT_W-1:0] limit;
  logic               is_ws;
  logic               is_word;
  logic [CNT_W-1:0]   n;
  logic [POSITION_BITS-1:0] pos_inc;

  function automatic result_t mk(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                 logic [POSITION_BITS-1:0] off,
                                 logic [POSITION_BITS-1:0] loff);
    result_t r;
    r.kind        = kind;
    r.data        = data;
    r.offset      = OUT_POS_W'(off);
    r.line_offset = OUT_POS_W'(loff);
    return r;
  endfunction

  assign limit   = (cfg.limit > LIMIT_CAP) ? LIMIT_CAP : cfg.limit;
  assign pos_inc = byte_position + POSITION_BITS'(1);

  assign is_ws = (data_byte == CH_SPACE) || (data_byte >= CH_TAB && data_byte <= CH_CR);
  assign is_word = (data_byte >= CH_DIGIT_LO && data_byte <= CH_DIGIT_HI) ||
                   (data_byte >= CH_UPPER_LO && data_byte <= CH_UPPER_HI) ||
                   (data_byte >= CH_LOWER_LO && data_byte <= CH_LOWER_HI) ||
                   (data_byte == CH_UNDERSCORE) ||
                   (cfg.minus_word && data_byte == CH_MINUS);

  always_comb begin
    in_word_next          = in_word;
    word_length_next      = word_length;
    newline_seen_next     = newline_seen;
    discarding_next       = discarding;
    line_count_next       = line_count;
    byte_position_next    = byte_position;
    line_start_next       = line_start;
    start_position_next   = start_position;
    start_line_start_next = start_line_start;
    n                     = '0;
    grp.line              = line_count;
    grp.slot              = '0;

    if (action == ACT_EOI) begin
      if (in_word && !discarding) begin
        grp.slot[n] = mk(KIND_END, '0, start_position, start_line_start);
        n = n + CNT_W'(1);
      end
      in_word_next          = 1'b0;
      word_length_next      = '0;
      newline_seen_next     = 1'b0;
      discarding_next       = 1'b0;
      line_count_next       = '0;
      byte_position_next    = '0;
      line_start_next       = '0;
      start_position_next   = '0;
      start_line_start_next = '0;
    end else begin
      if (in_word && !is_word) begin
        if (!discarding) begin
          grp.slot[n] = mk(KIND_END, '0, start_position, start_line_start);
          n = n + CNT_W'(1);
        end
        in_word_next     = 1'b0;
        discarding_next  = 1'b0;
        word_length_next = '0;
      end

      if (is_ws) begin
        if (data_byte == CH_LF) begin
          if (cfg.report_nl && !newline_seen) begin
            grp.slot[n] = mk(KIND_NEWLINE, '0, byte_position, line_start);
            n = n + CNT_W'(1);
          end
          newline_seen_next = 1'b1;
          line_count_next   = line_count + LINE_W'(1);
          line_start_next   = pos_inc;
        end
      end else begin
        newline_seen_next = 1'b0;
        if (!in_word_next) begin
          start_position_next   = byte_position;
          start_line_start_next = line_start;
          if (limit == '0) begin
            grp.slot[n] = mk(KIND_ERROR, '0, byte_position, line_start);
            n = n + CNT_W'(1);
            if (is_word) begin
              in_word_next     = 1'b1;
              discarding_next  = 1'b1;
              word_length_next = '0;
            end
          end else begin
            grp.slot[n] = mk(KIND_BYTE, data_byte, byte_position, line_start);
            n = n + CNT_W'(1);
            if (is_word) begin
              in_word_next     = 1'b1;
              word_length_next = LIMIT_W'(1);
            end else begin
              grp.slot[n] = mk(KIND_END, '0, byte_position, line_start);
              n = n + CNT_W'(1);
            end
          end
        end else if (!discarding_next) begin
          if (word_length >= limit) begin
            grp.slot[n] = mk(KIND_ERROR, '0, start_position, start_line_start);
            n = n + CNT_W'(1);
            discarding_next = 1'b1;
          end else begin
            grp.slot[n] = mk(KIND_BYTE, data_byte, start_position, start_line_start);
            n = n + CNT_W'(1);
            word_length_next = word_length + LIMIT_W'(1);
          end
        end
      end
      byte_position_next = pos_inc;
    end
    grp.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word          <= 1'b0;
      word_length      <= '0;
      newline_seen     <= 1'b0;
      discarding       <= 1'b0;
      line_count       <= '0;
      byte_position    <= '0;
      line_start       <= '0;
      start_position   <= '0;
      start_line_start <= '0;
    end else if (accept) begin
      in_word          <= in_word_next;
      word_length      <= word_length_next;
      newline_seen     <= newline_seen_next;
      discarding       <= discarding_next;
      line_count       <= line_count_next;
      byte_position    <= byte_position_next;
      line_start       <= line_start_next;
      start_position   <= start_position_next;
      start_line_start <= start_line_start_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bst_emit.sv -----
// Result register: holds one item's group of results and hands them out one
// transfer at a time, marking the last. Depends on bst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bst_emit (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     load,
  input  wire bst_pkg::group_t          grp_in,
  output logic                          in_ready,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output bst_pkg::result_t              out_res,
  output logic [bst_pkg::LINE_W-1:0]    out_line,
  output logic                          out_last
);
  import bst_pkg::*;

  group_t           grp;
  logic             grp_valid;
  logic [CNT_W-1:0] idx;
  logic             xfer;
  logic             drain;

  assign out_valid = grp_valid;
  assign out_res   = grp.slot[idx];
  assign out_line  = grp.line;
  assign out_last  = (idx == grp.count - CNT_W'(1));
  assign xfer      = grp_valid && out_ready;
  assign drain     = xfer && out_last;
  assign in_ready  = !grp_valid || drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= '0;
    end else if (load && grp_in.count != '0) begin
      grp_valid <= 1'b1;
      idx       <= '0;
    end else if (drain) begin
      grp_valid <= 1'b0;
      idx       <= '0;
    end else if (xfer) begin
      idx <= idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/byte_stream_tokenizer_top.sv -----
// Byte stream tokenizer top: config registers, step core and result register.
// First result of an item shows in the cycle after its input transfer.
// Throughput: one item per cycle while each yields one result at most and the
// output is ready; n results (up to 3) hold the result register until taken.
// Reset (rst, synchronous): counters and token state cleared, no result valid,
// registers back to newline reporting off, minus not a word byte, limit 1024.
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_tokenizer_top #(
  parameter int POSITION_BITS    = 32,
  parameter int LENGTH_LIMIT_MAX = 1024
) (
  input wire logic   clk,
  input wire logic   rst,
  bst_in_if.sink     bytes,
  bst_out_if.source  tokens,
  bst_cfg_if.sink    cfg
);
  import bst_pkg::*;

  cfg_t    cfg_reg;
  group_t  grp;
  result_t res;
  logic    accept;
  logic    in_ready;

  assign cfg.ready   = 1'b1;
  assign bytes.ready = in_ready;
  assign accept      = bytes.valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.report_nl  <= 1'b0;
      cfg_reg.minus_word <= 1'b0;
      cfg_reg.limit      <= LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_REPORT_NL:  cfg_reg.report_nl  <= cfg.data[0];
        REG_MINUS_WORD: cfg_reg.minus_word <= cfg.data[0];
        REG_LIMIT:      cfg_reg.limit      <= LIMIT_W'(cfg.data);
        default: ;
      endcase
    end
  end

  bst_core #(
    .POSITION_BITS    (POSITION_BITS),
    .LENGTH_LIMIT_MAX (LENGTH_LIMIT_MAX)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (bytes.action),
    .data_byte (bytes.data_byte),
    .cfg       (cfg_reg),
    .grp       (grp)
  );

  bst_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .grp_in    (grp),
    .in_ready  (in_ready),
    .out_valid (tokens.valid),
    .out_ready (tokens.ready),
    .out_res   (res),
    .out_line  (tokens.token_line),
    .out_last  (tokens.last)
  );

  assign tokens.out_kind          = res.kind;
  assign tokens.out_byte          = res.data;
  assign tokens.token_offset      = res.offset;
  assign tokens.token_line_offset = res.line_offset;

endmodule

`default_nettype wire

// ----- rtl/core/bst_checker.sv -----
// Port-level checks for the tokenizer top, attached by bind.
// Depends on bst_pkg and byte_stream_tokenizer_top.
`timescale 1ns / 1ps
`default_nettype none

module bst_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          out_last,
  input wire logic [bst_pkg::KIND_W-1:0]    out_kind,
  input wire logic [bst_pkg::OUT_POS_W-1:0] out_offset
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_offset))
    else $error("stalled result changed");

  a_group_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken while a result group is still pending");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

endmodule

bind byte_stream_tokenizer_top bst_checker u_bst_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (bytes.ready),
  .out_valid  (tokens.valid),
  .out_ready  (tokens.ready),
  .out_last   (tokens.last),
  .out_kind   (tokens.out_kind),
  .out_offset (tokens.token_offset)
);

`default_nettype wire
